### hdl/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the serial line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

  typedef enum logic [1:0] {
    CLS_CHAR,
    CLS_EOL,
    CLS_ERASE
  } cls_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    cls_t              cls;
    logic              echo;
  } entry_t;

endpackage

### hdl/serial_line_assembler_with_echo.sv
// With the back part idle, an accepted item passes the queue and the idle and
// echo states before its first result. Ordinary and erase bytes pass the idle
// and echo states; a line end adds a read and a line state per stored character,
// as each line byte waits on a registered read of the line store, then the
// marker state. A 2-item queue decouples input. Reset (rst, synchronous): fill
// count 0, echo on, queue and output emptied; the line store is not cleared.
// ----------------------------------------------------------------------------
// serial_line_assembler_with_echo
// Builds lines from received bytes with echo, erase and line release.
// ----------------------------------------------------------------------------
module serial_line_assembler_with_echo #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sla_pkg::BYTE_W-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sla_pkg::KIND_W-1:0] kind,
  output logic [sla_pkg::BYTE_W-1:0] data_byte,
  output logic [sla_pkg::LEN_W-1:0]  line_length,
  output logic                       last
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  sla_pkg::entry_t q_in;
  sla_pkg::entry_t q_out;

  sla_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  sla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .entry_out (q_out)
  );

  sla_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .line_length (line_length),
    .last        (last)
  );

endmodule

### hdl/sla_ram.sv
// ----------------------------------------------------------------------------
// sla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sla_front.sv
// ----------------------------------------------------------------------------
// sla_front
// Accepts received bytes, classifies them and tags them with the echo mode.
// ----------------------------------------------------------------------------
module sla_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sla_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       q_full,
  output logic                       q_push,
  output sla_pkg::entry_t            q_entry
);

  logic echo_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
    end else if (cfg_write) begin
      echo_enable <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.data = rx_byte;
    q_entry.echo = echo_enable;
    unique case (rx_byte) inside
      sla_pkg::CH_CR, sla_pkg::CH_LF:  q_entry.cls = sla_pkg::CLS_EOL;
      sla_pkg::CH_BS, sla_pkg::CH_DEL: q_entry.cls = sla_pkg::CLS_ERASE;
      default:                         q_entry.cls = sla_pkg::CLS_CHAR;
    endcase
  end

endmodule

### hdl/sla_queue.sv
// ----------------------------------------------------------------------------
// sla_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module sla_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sla_pkg::entry_t entry_in,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output sla_pkg::entry_t entry_out
);

  localparam int unsigned PW = $clog2(sla_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(sla_pkg::QUEUE_DEPTH + 1);

  sla_pkg::entry_t slots [sla_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = count == CW'(sla_pkg::QUEUE_DEPTH);
  assign valid     = count != '0;
  assign entry_out = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hdl/sla_back.sv
// ----------------------------------------------------------------------------
// sla_back
// Executes queued items: stores characters, echoes, erases, releases lines.
// ----------------------------------------------------------------------------
module sla_back #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  sla_pkg::entry_t            q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sla_pkg::KIND_W-1:0] kind,
  output logic [sla_pkg::BYTE_W-1:0] data_byte,
  output logic [sla_pkg::LEN_W-1:0]  line_length,
  output logic                       last
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned CW = $clog2(LINE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_RD,
    S_LINE,
    S_MARK
  } state_t;

  state_t                     state;
  sla_pkg::entry_t            cur;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              idx;
  logic                       can_load;
  logic                       echo_go;
  logic                       ram_we;
  logic                       ram_re;
  logic [sla_pkg::BYTE_W-1:0] ram_rdata;

  assign can_load = !out_valid || !out_stall;
  assign echo_go  = !cur.echo || can_load;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign ram_we   = (state == S_ECHO) && (cur.cls == sla_pkg::CLS_CHAR) && echo_go;
  assign ram_re   = state == S_RD;

  sla_ram #(
    .WIDTH (sla_pkg::BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata (cur.data),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_entry;
            idx <= '0;
            if (fill >= CW'(LINE_DEPTH)) begin
              fill <= '0;
            end
            state <= S_ECHO;
          end
        end
        S_ECHO: begin
          if (echo_go) begin
            if (cur.echo) begin
              out_valid   <= 1'b1;
              kind        <= sla_pkg::KIND_ECHO;
              data_byte   <= cur.data;
              line_length <= '0;
              last        <= cur.cls != sla_pkg::CLS_EOL;
            end
            unique case (cur.cls)
              sla_pkg::CLS_CHAR: begin
                fill  <= fill + CW'(1);
                state <= S_IDLE;
              end
              sla_pkg::CLS_ERASE: begin
                if (fill != '0) begin
                  fill <= fill - CW'(1);
                end
                state <= S_IDLE;
              end
              sla_pkg::CLS_EOL: begin
                state <= (fill == '0) ? S_MARK : S_RD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          state <= S_LINE;
        end
        S_LINE: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            kind        <= sla_pkg::KIND_LINE;
            data_byte   <= ram_rdata;
            line_length <= '0;
            last        <= 1'b0;
            idx         <= idx + CW'(1);
            state       <= (idx + CW'(1) == fill) ? S_MARK : S_RD;
          end
        end
        S_MARK: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            kind        <= sla_pkg::KIND_MARK;
            data_byte   <= '0;
            line_length <= sla_pkg::LEN_W'(fill);
            last        <= 1'b1;
            fill        <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/sla_checker.sv
// ----------------------------------------------------------------------------
// sla_checker
// Port-level checks of the serial line assembler, bound to the top level.
// ----------------------------------------------------------------------------
module sla_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sla_pkg::KIND_W-1:0] kind,
  input logic [sla_pkg::BYTE_W-1:0] data_byte,
  input logic [sla_pkg::LEN_W-1:0]  line_length,
  input logic                       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sla_pkg::KIND_MARK |-> last && data_byte == '0)
    else $error("line end marker malformed");

  a_line_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sla_pkg::KIND_LINE |-> !last)
    else $error("line byte flagged last");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sla_pkg::KIND_MARK |-> line_length == '0)
    else $error("length on non-marker result");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == sla_pkg::KIND_ECHO || kind == sla_pkg::KIND_LINE ||
                  kind == sla_pkg::KIND_MARK)
    else $error("illegal result kind");

endmodule

bind serial_line_assembler_with_echo sla_checker u_sla_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial line assembler. A directed table covers
// the byte extremes, erase on an empty line, empty lines, echo on and off, the
// longest line and the full-store wrap. Random lines of random content follow,
// with erases and noise mixed in. Every result is checked against a local
// model of the line store, with random gaps on input and random output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH      = 32;
  localparam int SETTLE     = 24;
  localparam int RAND_ITEMS = 270;

  typedef struct packed {
    logic [sla_pkg::KIND_W-1:0] kind;
    logic [sla_pkg::BYTE_W-1:0] data;
    logic [sla_pkg::LEN_W-1:0]  len;
    logic                       last;
  } res_t;

  typedef enum logic [1:0] {
    R_BYTE,
    R_RUN,
    R_CFG
  } row_op_t;

  // typed: expected results given in e0/e1 (count in nexp), else predicted
  typedef struct packed {
    row_op_t     op;
    logic [7:0]  val;
    logic [7:0]  cnt;
    logic        typed;
    logic [1:0]  nexp;
    res_t        e0;
    res_t        e1;
  } row_t;

  localparam res_t NO_RES = '0;
  localparam int   N_ROWS = 23;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic                       cfg_data  = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [sla_pkg::BYTE_W-1:0] rx_byte   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [sla_pkg::KIND_W-1:0] kind;
  logic [sla_pkg::BYTE_W-1:0] data_byte;
  logic [sla_pkg::LEN_W-1:0]  line_length;
  logic                       last;

  logic [sla_pkg::BYTE_W-1:0] line_mem [DEPTH];
  int                         line_fill = 0;
  logic                       echo_on   = 1'b1;
  res_t                       pending_results [$];
  int                         mismatches = 0;
  int                         items_sent = 0;
  int                         stall_left = 0;
  bit                         burst      = 1'b0;

  row_t plan [N_ROWS] = '{
    '{R_BYTE, sla_pkg::CH_CR,  8'd0,  1'b1, 2'd2,
      '{sla_pkg::KIND_ECHO, sla_pkg::CH_CR, 6'd0, 1'b0},
      '{sla_pkg::KIND_MARK, 8'h00, 6'd0, 1'b1}},
    '{R_BYTE, sla_pkg::CH_BS,  8'd0,  1'b1, 2'd1,
      '{sla_pkg::KIND_ECHO, sla_pkg::CH_BS, 6'd0, 1'b1}, NO_RES},
    '{R_BYTE, sla_pkg::CH_DEL, 8'd0,  1'b1, 2'd1,
      '{sla_pkg::KIND_ECHO, sla_pkg::CH_DEL, 6'd0, 1'b1}, NO_RES},
    '{R_BYTE, 8'h00,  8'd0,  1'b1, 2'd1,
      '{sla_pkg::KIND_ECHO, 8'h00, 6'd0, 1'b1}, NO_RES},
    '{R_BYTE, 8'hFF,  8'd0,  1'b1, 2'd1,
      '{sla_pkg::KIND_ECHO, 8'hFF, 6'd0, 1'b1}, NO_RES},
    '{R_BYTE, 8'h41,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_BS,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, 8'h42,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_LF,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_LF,  8'd0,  1'b1, 2'd2,
      '{sla_pkg::KIND_ECHO, sla_pkg::CH_LF, 6'd0, 1'b0},
      '{sla_pkg::KIND_MARK, 8'h00, 6'd0, 1'b1}},
    '{R_CFG,  8'h00,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, 8'h31,  8'd0,  1'b1, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_DEL, 8'd0,  1'b1, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_CR,  8'd0,  1'b1, 2'd1,
      '{sla_pkg::KIND_MARK, 8'h00, 6'd0, 1'b1}, NO_RES},
    '{R_BYTE, 8'h55,  8'd0,  1'b1, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, 8'hAA,  8'd0,  1'b1, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_CR,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_CFG,  8'h01,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_RUN,  8'h20,  8'd31, 1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_CR,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_RUN,  8'h80,  8'd34, 1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_DEL, 8'd0,  1'b0, 2'd0, NO_RES, NO_RES},
    '{R_BYTE, sla_pkg::CH_LF,  8'd0,  1'b0, 2'd0, NO_RES, NO_RES}
  };

  serial_line_assembler_with_echo #(
    .LINE_DEPTH(DEPTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .line_length(line_length),
    .last       (last)
  );

  always #6 clk = ~clk;

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic predict_byte(input logic [sla_pkg::BYTE_W-1:0] b, input bit keep);
    res_t r [$];
    if (line_fill >= DEPTH) line_fill = 0;
    line_mem[line_fill] = b;
    if (echo_on) r.push_back(res_t'{sla_pkg::KIND_ECHO, b, 6'd0, 1'b0});
    if (b == sla_pkg::CH_CR || b == sla_pkg::CH_LF) begin
      line_mem[line_fill] = '0;
      for (int k = 0; k < line_fill; k++)
        r.push_back(res_t'{sla_pkg::KIND_LINE, line_mem[k], 6'd0, 1'b0});
      r.push_back(res_t'{sla_pkg::KIND_MARK, 8'h00, 6'(line_fill), 1'b0});
      line_fill = 0;
    end else if (b == sla_pkg::CH_BS || b == sla_pkg::CH_DEL) begin
      if (line_fill > 0) line_fill--;
    end else begin
      line_fill++;
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    if (keep) foreach (r[k]) pending_results.push_back(r[k]);
  endtask

  // Leaves in_valid high on return; the caller lowers it or sends again.
  task automatic send_byte(input logic [sla_pkg::BYTE_W-1:0] b, input bit keep);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_byte(b, keep);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_echo(input logic v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    echo_on = v;
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h length %0d last %0d",
               kind, data_byte, line_length, last);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, kind);
          mismatches++;
        end
        if (data_byte !== e.data) begin
          $error("data_byte: expected %0h, actual %0h", e.data, data_byte);
          mismatches++;
        end
        if (line_length !== e.len) begin
          $error("line_length: expected %0d, actual %0d", e.len, line_length);
          mismatches++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, last);
          mismatches++;
        end
      end
      stall_left = draw_gap();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  initial begin
    #(12 * 500000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int                         lines;
    int                         len;
    int                         pick;
    int                         target;
    logic [sla_pkg::BYTE_W-1:0] b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      case (plan[i].op)
        R_CFG: begin
          drain();
          write_echo(plan[i].val[0]);
        end
        R_RUN: begin
          for (int j = 0; j < plan[i].cnt; j++)
            send_byte(plan[i].val + 8'(j), 1'b1);
        end
        default: begin
          send_byte(plan[i].val, !plan[i].typed);
          if (plan[i].typed && plan[i].nexp >= 2'd1) pending_results.push_back(plan[i].e0);
          if (plan[i].typed && plan[i].nexp == 2'd2) pending_results.push_back(plan[i].e1);
        end
      endcase
    end

    target = items_sent + RAND_ITEMS;
    while (items_sent < target) begin
      drain();
      write_echo(1'($urandom_range(0, 1)));
      burst = ($urandom_range(0, 3) == 0);
      lines = $urandom_range(4, 10);
      for (int l = 0; l < lines; l++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
        for (int j = 0; j < len; j++) begin
          b    = 8'($urandom_range(0, 255));
          pick = $urandom_range(0, 15);
          if (pick == 1) b = sla_pkg::CH_BS;
          else if (pick == 2) b = sla_pkg::CH_DEL;
          else if (pick != 0 && (b == sla_pkg::CH_CR || b == sla_pkg::CH_LF)) b = b ^ 8'h20;
          send_byte(b, 1'b1);
        end
        if ($urandom_range(0, 9) != 0)
          send_byte($urandom_range(0, 1) ? sla_pkg::CH_CR : sla_pkg::CH_LF, 1'b1);
      end
    end

    burst = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### serial_line_assembler_with_echo.f
hdl/sla_pkg.sv
hdl/sla_ram.sv
hdl/sla_front.sv
hdl/sla_queue.sv
hdl/sla_back.sv
hdl/serial_line_assembler_with_echo.sv
hdl/sla_checker.sv
tb/tb_top.sv
